// File: hw/rtl/gcc_pkg.sv
// Shared types and constants for the greedy coin change block.
package gcc_pkg;

  localparam int AMOUNT_W   = 16;  // width of the amount field on the stream
  localparam int VALUE_W    = 16;  // width of one coin denomination
  localparam int COUNT_W    = 3;   // width of the coin count register
  localparam int NUM_SLOTS  = 6;   // coin value registers in the register map
  localparam int SLOT_IDX_W = 3;   // index into the sorted coin table
  localparam int REG_IDX_W  = 3;   // width of the configuration register index
  localparam int QDEPTH     = 4;   // amount queue between front and back
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int DIGIT_BITS = 4;   // quotient bits resolved per divider cycle
  localparam int OUT_DATA_W = 64;  // coin_value, coins_used, total_coins, leftover

  // Register map
  localparam logic [REG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] NUM_REGS         = 3'd7;

  // Record kinds carried in tuser
  localparam logic REC_COIN  = 1'b0;
  localparam logic REC_TOTAL = 1'b1;

  // Denominations in use, largest first, stable on ties
  typedef struct packed {
    logic [NUM_SLOTS-1:0][VALUE_W-1:0] value;
    logic [COUNT_W-1:0]                count;
  } coin_table_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_TOTAL
  } back_state_t;

endpackage

// File: hw/rtl/gcc_front.sv
// Front end: configuration registers, sorted coin table and amount queue.
module gcc_front #(
  parameter int MAX_COINS = 6,
  parameter int AW        = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gcc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [gcc_pkg::VALUE_W-1:0]   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gcc_pkg::AMOUNT_W-1:0]  s_axis_tdata,
  input  logic                          pop,
  output logic                          head_valid,
  output logic [AW-1:0]                 head_amount,
  output gcc_pkg::coin_table_t          tbl
);
  import gcc_pkg::*;

  logic [COUNT_W-1:0]               coin_count;
  logic [NUM_SLOTS-1:0][VALUE_W-1:0] coin_val;
  logic [REG_IDX_W-1:0]             slot_sel;

  coin_table_t                      tbl_next;
  logic [NUM_SLOTS-1:0]             in_use;
  logic [NUM_SLOTS-1:0][SLOT_IDX_W-1:0] rank;
  logic [COUNT_W-1:0]               n_eff;

  logic [AW-1:0]     queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] qcount;
  logic              push;

  assign slot_sel = cfg_index - REG_COIN_VALUE_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count <= COUNT_W'(1);
      for (int i = 0; i < NUM_SLOTS; i++) coin_val[i] <= VALUE_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_COIN_COUNT) begin
        coin_count <= cfg_data[COUNT_W-1:0];
      end else if (cfg_index < NUM_REGS) begin
        coin_val[slot_sel] <= cfg_data;
      end
    end
  end

  // Rank each usable entry: larger values first, register order on ties
  always_comb begin
    logic [SLOT_IDX_W-1:0] r;
    n_eff = (coin_count > COUNT_W'(MAX_COINS)) ? COUNT_W'(MAX_COINS) : coin_count;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      in_use[i] = (COUNT_W'(i) < n_eff) && (coin_val[i] != '0);
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      r = '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j != i && in_use[j] &&
            (coin_val[j] > coin_val[i] || (coin_val[j] == coin_val[i] && j < i))) begin
          r = r + SLOT_IDX_W'(1);
        end
      end
      rank[i] = r;
    end
    tbl_next = '0;
    for (int p = 0; p < NUM_SLOTS; p++) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (in_use[i] && rank[i] == SLOT_IDX_W'(p)) tbl_next.value[p] = coin_val[i];
      end
    end
    tbl_next.count = COUNT_W'($countones(in_use));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // One coin of value 1 in the first slot
      tbl <= {(NUM_SLOTS*VALUE_W)'(1), COUNT_W'(1)};
    end else begin
      tbl <= tbl_next;
    end
  end

  // Amount queue
  assign s_axis_tready = (qcount != QCNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid    = (qcount != '0);
  assign head_amount   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= s_axis_tdata[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcount <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      qcount <= qcount + QCNT_W'(1);
      else if (!push && pop) qcount <= qcount - QCNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/gcc_divider.sv
// Iterative restoring divider, DIGIT_BITS quotient bits per cycle.
module gcc_divider #(
  parameter int AW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [AW-1:0]               dividend,
  input  logic [gcc_pkg::VALUE_W-1:0] divisor,
  output logic                        done,
  output logic [AW-1:0]               quotient,
  output logic [AW-1:0]               remainder,
  output logic [gcc_pkg::VALUE_W-1:0] divisor_q
);
  import gcc_pkg::*;

  localparam int NCYC = (AW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW   = NCYC * DIGIT_BITS;
  localparam int CW   = $clog2(NCYC + 1);

  logic [VALUE_W-1:0]    rem;
  logic [VALUE_W-1:0]    rem_next;
  logic [PW-1:0]         sh;
  logic [PW-1:0]         quo;
  logic [DIGIT_BITS-1:0] qd;
  logic [CW-1:0]         cnt;
  logic                  running;

  always_comb begin
    logic [VALUE_W:0]   t;
    logic [VALUE_W-1:0] r;
    r  = rem;
    qd = '0;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      t = {r, sh[PW-1-k]};
      if (t >= {1'b0, divisor_q}) begin
        r = VALUE_W'(t - {1'b0, divisor_q});
        qd[DIGIT_BITS-1-k] = 1'b1;
      end else begin
        r = t[VALUE_W-1:0];
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= '0;
      sh        <= PW'(dividend);
      quo       <= '0;
      divisor_q <= divisor;
    end else if (running) begin
      rem <= rem_next;
      sh  <= sh << DIGIT_BITS;
      quo <= (quo << DIGIT_BITS) | PW'(qd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CW'(NCYC - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NCYC - 1)) running <= 1'b0;
      end
    end
  end

  assign quotient  = quo[AW-1:0];
  assign remainder = rem[AW-1:0];

endmodule

// File: hw/rtl/gcc_back.sv
// Back end: walks the sorted coin table per amount and emits records.
module gcc_back #(
  parameter int AW = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gcc_pkg::coin_table_t           tbl,
  input  logic                           head_valid,
  input  logic [AW-1:0]                  head_amount,
  output logic                           pop,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import gcc_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [SLOT_IDX_W-1:0] idx;
  logic [SLOT_IDX_W-1:0] idx_inc;
  logic [SLOT_IDX_W-1:0] rd_idx;
  logic [AW-1:0]         amt;
  logic [VALUE_W-1:0]    total;
  logic                  is_last;
  logic                  slot_free;

  logic                  div_start;
  logic [AW-1:0]         div_dividend;
  logic                  div_done;
  logic [AW-1:0]         div_q;
  logic [AW-1:0]         div_r;
  logic [VALUE_W-1:0]    div_dvs;

  logic                  advance;
  logic                  emit_coin;
  logic                  emit_total;

  logic                  out_valid;
  logic                  out_kind;
  logic                  out_last;
  logic [VALUE_W-1:0]    out_value;
  logic [VALUE_W-1:0]    out_used;
  logic [VALUE_W-1:0]    out_total;
  logic [VALUE_W-1:0]    out_left;

  assign idx_inc   = idx + SLOT_IDX_W'(1);
  assign is_last   = (idx_inc == tbl.count);
  assign slot_free = !out_valid || m_axis_tready;

  gcc_divider #(.AW(AW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (tbl.value[rd_idx]),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r),
    .divisor_q (div_dvs)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) state_next = (tbl.count == '0) ? ST_TOTAL : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (div_q == '0 || slot_free) state_next = is_last ? ST_TOTAL : ST_DIV;
      end
      ST_TOTAL: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = head_amount;
    rd_idx       = '0;
    advance      = 1'b0;
    emit_coin    = 1'b0;
    emit_total   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop       = head_valid;
        div_start = head_valid && (tbl.count != '0);
      end
      ST_DIV: begin
      end
      ST_EMIT: begin
        div_dividend = div_r;
        rd_idx       = idx_inc;
        if (div_q == '0 || slot_free) begin
          advance   = 1'b1;
          emit_coin = (div_q != '0);
          div_start = !is_last;
        end
      end
      ST_TOTAL: begin
        emit_total = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (pop)          idx <= '0;
      else if (advance) idx <= idx_inc;
    end
  end

  // Running amount and coin total for the item in flight
  always_ff @(posedge clk) begin
    if (pop) begin
      amt   <= head_amount;
      total <= '0;
    end else if (advance) begin
      amt   <= div_r;
      total <= total + VALUE_W'(div_q);
    end
  end

  // Output register: hold while stalled, refill as soon as the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_coin || emit_total) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_coin) begin
      out_kind  <= REC_COIN;
      out_value <= div_dvs;
      out_used  <= VALUE_W'(div_q);
      out_total <= '0;
      out_left  <= '0;
      out_last  <= 1'b0;
    end else if (emit_total) begin
      out_kind  <= REC_TOTAL;
      out_value <= '0;
      out_used  <= '0;
      out_total <= total;
      out_left  <= VALUE_W'(amt);
      out_last  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_left, out_total, out_used, out_value};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

// File: hw/rtl/greedy_coin_change_top.sv
// Top level of the greedy coin change block.
//
// Usage: write coin_count (index 0) and coin_value_0..5 (index 1..6) through
// cfg_we/cfg_index/cfg_data while the block is idle; the sorted coin table
// is rebuilt and registered after each write. Then stream amounts in on s_axis.
// For each amount the block returns one word per denomination with a nonzero
// count, largest first, then a closing total word with tlast high.
//
// The back end takes one amount at a time from the queue and divides it by
// each denomination in use in turn, largest first, on the shared divider,
// which resolves four quotient bits a cycle; the closing total word follows
// the last denomination.
//
// A four-deep amount queue decouples input from the back end, so s_axis
// keeps accepting while words wait. When the receiver stalls, the output
// word holds, the back end pauses, and s_axis_tready drops once the queue is
// full. Reset clears the queue, the output word and the registers (count 1,
// all values 1).
module greedy_coin_change_top #(
  parameter int MAX_COINS   = 6,
  parameter int AMOUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gcc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [gcc_pkg::VALUE_W-1:0]    cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gcc_pkg::AMOUNT_W-1:0]   s_axis_tdata,  // [15:0] amount
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] coin_value, [31:16] coins_used, [47:32] total_coins, [63:48] leftover
  output logic [gcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,  // [0] record_kind
  output logic                           m_axis_tlast
);
  import gcc_pkg::*;

  // Amounts wider than the stream field add nothing
  localparam int AW = (AMOUNT_BITS < AMOUNT_W) ? AMOUNT_BITS : AMOUNT_W;

  coin_table_t   tbl;
  logic          head_valid;
  logic [AW-1:0] head_amount;
  logic          pop;

  gcc_front #(.MAX_COINS(MAX_COINS), .AW(AW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pop           (pop),
    .head_valid    (head_valid),
    .head_amount   (head_amount),
    .tbl           (tbl)
  );

  gcc_back #(.AW(AW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .tbl           (tbl),
    .head_valid    (head_valid),
    .head_amount   (head_amount),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hw/rtl/gcc_checker.sv
// Port-level checks for the greedy coin change block, bound to the top level.
module gcc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [gcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import gcc_pkg::*;

  // A stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // Only the total word closes an amount
  a_last_is_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == REC_TOTAL)))
    else $error("tlast and record kind disagree");

  // A coin word carries a denomination and a nonzero count, no totals
  a_coin_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == REC_COIN |->
      m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[31:16] != 16'd0 &&
      m_axis_tdata[63:32] == 32'd0)
    else $error("malformed coin word");

  // A total word carries no denomination or count
  a_total_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == REC_TOTAL |-> m_axis_tdata[31:0] == 32'd0)
    else $error("malformed total word");

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind greedy_coin_change_top gcc_checker u_gcc_checker (.*);
